[rtl/arp_address_resolver_defines.svh]
// Assertion macros shared by the resolver RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ARP_ADDRESS_RESOLVER_DEFINES_SVH
`define ARP_ADDRESS_RESOLVER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ARP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ARP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/arp_pkg.sv]
// Types and constants of the ARP resolver.
// No dependencies; imported by arp_core and arp_address_resolver.
package arp_pkg;

    // action codes of an input word
    localparam logic [2:0] ACT_TICK  = 3'd0;
    localparam logic [2:0] ACT_START = 3'd1;
    localparam logic [2:0] ACT_FRAME = 3'd2;
    localparam logic [2:0] ACT_RXERR = 3'd3;
    localparam logic [2:0] ACT_TXERR = 3'd4;

    // result kinds
    localparam logic [2:0] KIND_SEND     = 3'd0;
    localparam logic [2:0] KIND_RESOLVED = 3'd1;
    localparam logic [2:0] KIND_TIMEOUT  = 3'd2;
    localparam logic [2:0] KIND_RXERR    = 3'd3;
    localparam logic [2:0] KIND_TXERR    = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_OWN_MAC     = 2'd0;
    localparam logic [1:0] CFG_FIRST_WAIT  = 2'd1;
    localparam logic [1:0] CFG_SECOND_WAIT = 2'd2;

    localparam logic [15:0] FIRST_WAIT_RESET  = 16'd2000;
    localparam logic [15:0] SECOND_WAIT_RESET = 16'd3000;

    // ARP message constants
    localparam logic [4:0]  ARP_MSG_BYTES  = 5'd28;
    localparam logic [15:0] ARP_OP_REQUEST = 16'h0001;
    localparam logic [15:0] ARP_OP_REPLY   = 16'h0002;
    localparam logic [15:0] ARP_HTYPE_ETH  = 16'h0001;
    localparam logic [15:0] ARP_PTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] source_ip;
        logic [31:0] target_ip;
        logic [4:0]  frame_length;
        logic [15:0] frame_opcode;
        logic [47:0] frame_sender_mac;
        logic [31:0] frame_sender_ip;
    } arp_item_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [31:0] request_sender_ip;
        logic [31:0] request_target_ip;
        logic [47:0] found_mac;
    } arp_result_t;

    // wait periods handed from the register file to the core
    typedef struct packed {
        logic [15:0] first_wait_ticks;
        logic [15:0] second_wait_ticks;
    } arp_waits_t;

endpackage

[rtl/arp_core.sv]
// Resolver state machine and result register.
// Depends on arp_pkg and arp_address_resolver_defines.svh.
`include "arp_address_resolver_defines.svh"

module arp_core
    import arp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  arp_item_t   item,
    input  arp_waits_t  waits,
    output logic        take,
    output logic        out_valid,
    input  logic        out_ready,
    output arp_result_t result
);

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] countdown_reg, countdown_next;
    logic [31:0] held_source_ip_reg, held_source_ip_next;
    logic [31:0] held_target_ip_reg, held_target_ip_next;
    logic        out_valid_reg, out_valid_next;
    arp_result_t result_reg, result_next;

    logic        busy;
    logic        emit;
    arp_result_t res;

    // result slot is free when empty or being drained this cycle
    assign take = item_valid && (!out_valid_reg || out_ready);
    assign busy = (phase_reg == PH_FIRST) || (phase_reg == PH_SECOND);

    always_comb
    begin
        phase_next          = phase_reg;
        countdown_next      = countdown_reg;
        held_source_ip_next = held_source_ip_reg;
        held_target_ip_next = held_target_ip_reg;
        emit                = 1'b0;
        res                 = '0;

        if (!busy) begin
            if (item.action == ACT_START)
            begin
                held_source_ip_next   = item.source_ip;
                held_target_ip_next   = item.target_ip;
                countdown_next        = waits.first_wait_ticks;
                phase_next            = PH_FIRST;
                emit                  = 1'b1;
                res.result_kind       = KIND_SEND;
                res.request_sender_ip = item.source_ip;
                res.request_target_ip = item.target_ip;
            end
        end
        else
        begin
            case (item.action)
                ACT_TICK:
                begin
                    if (countdown_reg > 16'd1)
                    begin
                        countdown_next = countdown_reg - 16'd1;
                    end
                    else if (phase_reg == PH_FIRST)
                    begin
                        // first wait over: resend
                        countdown_next        = waits.second_wait_ticks;
                        phase_next            = PH_SECOND;
                        emit                  = 1'b1;
                        res.result_kind       = KIND_SEND;
                        res.request_sender_ip = held_source_ip_reg;
                        res.request_target_ip = held_target_ip_reg;
                    end
                    else
                    begin
                        countdown_next  = '0;
                        phase_next      = PH_IDLE;
                        emit            = 1'b1;
                        res.result_kind = KIND_TIMEOUT;
                    end
                end
                ACT_FRAME:
                begin
                    if (item.frame_length >= ARP_MSG_BYTES
                        && item.frame_opcode == ARP_OP_REPLY
                        && item.frame_sender_ip == held_target_ip_reg)
                    begin
                        countdown_next  = '0;
                        phase_next      = PH_IDLE;
                        emit            = 1'b1;
                        res.result_kind = KIND_RESOLVED;
                        res.found_mac   = item.frame_sender_mac;
                    end
                end
                ACT_RXERR:
                begin
                    countdown_next  = '0;
                    phase_next      = PH_IDLE;
                    emit            = 1'b1;
                    res.result_kind = KIND_RXERR;
                end
                ACT_TXERR:
                begin
                    // only the first send can fail the resolve
                    if (phase_reg == PH_FIRST)
                    begin
                        countdown_next  = '0;
                        phase_next      = PH_IDLE;
                        emit            = 1'b1;
                        res.result_kind = KIND_TXERR;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (take)
        begin
            out_valid_next = emit;
            result_next    = res;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
            result_next    = result_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            countdown_reg      <= '0;
            held_source_ip_reg <= '0;
            held_target_ip_reg <= '0;
            out_valid_reg      <= 1'b0;
            result_reg         <= '0;
        end
        else
        begin
            if (take)
            begin
                phase_reg          <= phase_next;
                countdown_reg      <= countdown_next;
                held_source_ip_reg <= held_source_ip_next;
                held_target_ip_reg <= held_target_ip_next;
            end
            out_valid_reg <= out_valid_next;
            result_reg    <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // assertions
    `ARP_ASSERT_SAME(a_idle_count_zero, clk, rst_n,
        phase_reg == PH_IDLE, countdown_reg == 16'd0,
        "countdown left nonzero while idle")
    `ARP_ASSERT_NEXT(a_idle_ignores, clk, rst_n,
        take && phase_reg == PH_IDLE && item.action != ACT_START,
        phase_reg == PH_IDLE,
        "non-start word left idle")
    `ARP_ASSERT_NEXT(a_no_return_first, clk, rst_n,
        take && phase_reg == PH_SECOND, phase_reg != PH_FIRST,
        "second wait went back to first wait")
    `ARP_ASSERT_SAME(a_ip_only_on_send, clk, rst_n,
        out_valid_reg && result_reg.result_kind != KIND_SEND,
        result_reg.request_sender_ip == 32'd0 && result_reg.request_target_ip == 32'd0,
        "request address fields set on a non-send result")

endmodule

[rtl/arp_address_resolver.sv]
// ARP resolver with one retry: input register, config registers, core.
// Depends on arp_pkg and arp_core.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word per event: a
//   millisecond tick, a start with source and target IPv4 addresses, a
//   received ARP message, a receive error or a failed first send.
//   Output channel (out_valid/out_ready) returns at most one word per
//   input word: send request, resolved MAC, timeout, receive error or
//   send error. Words that cause no result are simply consumed.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   own_mac (0), first_wait_ticks (1), second_wait_ticks (2); other
//   indexes are dropped. cfg_ready is always high; write only when idle.
// Timing:
//   A word lands in the input register; once the result slot is free, the
//   state machine updates from it and loads the result register.
//   Throughput is one word per cycle while out_ready keeps the result slot free.
// Reset (rst_n low, async): state idle, counters and held addresses zero,
//   waits back to 2000 and 3000 ticks, no result pending.
// Stall: while out_ready is low and a result is held, the input register
//   holds its word and in_ready drops once that register is full.
module arp_address_resolver
    import arp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  action,
    input  logic [31:0] source_ip,
    input  logic [31:0] target_ip,
    input  logic [4:0]  frame_length,
    input  logic [15:0] frame_opcode,
    input  logic [47:0] frame_sender_mac,
    input  logic [31:0] frame_sender_ip,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  result_kind,
    output logic [31:0] request_sender_ip,
    output logic [31:0] request_target_ip,
    output logic [47:0] found_mac,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    logic        in_valid_reg;
    arp_item_t   item_reg;
    logic        take;
    arp_result_t result;

    // config registers; own_mac_reg is held here but feeds no output
    logic [47:0] own_mac_reg;
    arp_waits_t  waits_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg                 <= '0;
            waits_reg.first_wait_ticks  <= FIRST_WAIT_RESET;
            waits_reg.second_wait_ticks <= SECOND_WAIT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_OWN_MAC:     own_mac_reg                 <= cfg_data;
                CFG_FIRST_WAIT:  waits_reg.first_wait_ticks  <= cfg_data[15:0];
                CFG_SECOND_WAIT: waits_reg.second_wait_ticks <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // input register: refills in the same cycle the core takes its word
    assign in_ready = !in_valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            item_reg     <= '0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
            if (in_valid)
            begin
                item_reg.action           <= action;
                item_reg.source_ip        <= source_ip;
                item_reg.target_ip        <= target_ip;
                item_reg.frame_length     <= frame_length;
                item_reg.frame_opcode     <= frame_opcode;
                item_reg.frame_sender_mac <= frame_sender_mac;
                item_reg.frame_sender_ip  <= frame_sender_ip;
            end
        end
    end

    arp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .item       (item_reg),
        .waits      (waits_reg),
        .take       (take),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (result)
    );

    assign result_kind       = result.result_kind;
    assign request_sender_ip = result.request_sender_ip;
    assign request_target_ip = result.request_target_ip;
    assign found_mac         = result.found_mac;

endmodule
